// ===== rtl/tme_pkg.sv =====
// Shared constants, codes and types of the tiny machine executor.
package tme_pkg;

	localparam int MEM_WORDS_DEF = 1024;
	localparam int NUM_REGS_DEF  = 8;
	localparam int WORD_BITS_DEF = 32;

	localparam logic [3:0] OP_LD   = 4'd0;
	localparam logic [3:0] OP_ST   = 4'd1;
	localparam logic [3:0] OP_LDC  = 4'd2;
	localparam logic [3:0] OP_ADD  = 4'd3;
	localparam logic [3:0] OP_SUB  = 4'd4;
	localparam logic [3:0] OP_MUL  = 4'd5;
	localparam logic [3:0] OP_DIV  = 4'd6;
	localparam logic [3:0] OP_OUT  = 4'd7;
	localparam logic [3:0] OP_HALT = 4'd8;

	localparam logic [2:0] ST_OK      = 3'd0;
	localparam logic [2:0] ST_OUT     = 3'd1;
	localparam logic [2:0] ST_HALT    = 3'd2;
	localparam logic [2:0] ST_DIVZ    = 3'd3;
	localparam logic [2:0] ST_BADADDR = 3'd4;
	localparam logic [2:0] ST_UNKNOWN = 3'd5;
	localparam logic [2:0] ST_BADREG  = 3'd6;
	localparam logic [2:0] ST_STOPPED = 3'd7;

	typedef struct packed {
		logic start;
		logic is_div;
	} md_req_t;

endpackage

// ===== rtl/tme_regfile.sv =====
// Register file: two synchronous read ports, one write port.
module tme_regfile #(
	parameter int NUM_REGS  = tme_pkg::NUM_REGS_DEF,
	parameter int WORD_BITS = tme_pkg::WORD_BITS_DEF,
	parameter int RIDX_W    = $clog2(NUM_REGS)
) (
	input  logic                 clk,
	input  logic                 re,
	input  logic [RIDX_W-1:0]    ra_addr,
	input  logic [RIDX_W-1:0]    rb_addr,
	input  logic                 we,
	input  logic [RIDX_W-1:0]    wa_addr,
	input  logic [WORD_BITS-1:0] wdata,
	output logic [WORD_BITS-1:0] ra_data,
	output logic [WORD_BITS-1:0] rb_data
);
	import tme_pkg::*;

	logic [WORD_BITS-1:0] regs [NUM_REGS];

	always_ff @(posedge clk) begin
		if (we) begin
			regs[wa_addr] <= wdata;
		end
		if (re) begin
			ra_data <= regs[ra_addr];
			rb_data <= regs[rb_addr];
		end
	end

endmodule

// ===== rtl/tme_dmem.sv =====
// Data memory: single port, synchronous read.
module tme_dmem #(
	parameter int MEM_WORDS = tme_pkg::MEM_WORDS_DEF,
	parameter int WORD_BITS = tme_pkg::WORD_BITS_DEF,
	parameter int AW        = $clog2(MEM_WORDS)
) (
	input  logic                 clk,
	input  logic                 en,
	input  logic                 we,
	input  logic [AW-1:0]        addr,
	input  logic [WORD_BITS-1:0] wdata,
	output logic [WORD_BITS-1:0] rdata
);
	import tme_pkg::*;

	logic [WORD_BITS-1:0] mem [MEM_WORDS];

	always_ff @(posedge clk) begin
		if (en) begin
			if (we) begin
				mem[addr] <= wdata;
			end else begin
				rdata <= mem[addr];
			end
		end
	end

endmodule

// ===== rtl/tme_muldiv.sv =====
// Bit-serial multiplier and signed divider, one bit per cycle.
module tme_muldiv #(
	parameter int WORD_BITS = tme_pkg::WORD_BITS_DEF
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  tme_pkg::md_req_t     req,
	input  logic [WORD_BITS-1:0] a,
	input  logic [WORD_BITS-1:0] b,
	output logic                 done,
	output logic [WORD_BITS-1:0] result
);
	import tme_pkg::*;

	localparam int CNT_W = $clog2(WORD_BITS);

	logic                 busy_q;
	logic                 fix_q;
	logic                 done_q;
	logic [CNT_W-1:0]     cnt_q;
	logic                 div_q;
	logic                 neg_q;
	logic [WORD_BITS-1:0] x_q;
	logic [WORD_BITS-1:0] y_q;
	logic [WORD_BITS-1:0] r_q;
	logic [WORD_BITS-1:0] res_q;

	logic [WORD_BITS-1:0] mag_a;
	logic [WORD_BITS-1:0] mag_b;
	logic [WORD_BITS:0]   trial;
	logic [WORD_BITS:0]   diff;
	logic                 ge;
	logic                 last;

	assign mag_a = a[WORD_BITS-1] ? (~a + WORD_BITS'(1)) : a;
	assign mag_b = b[WORD_BITS-1] ? (~b + WORD_BITS'(1)) : b;
	assign trial = {r_q, x_q[WORD_BITS-1]};
	assign diff  = trial - {1'b0, y_q};
	assign ge    = (trial >= {1'b0, y_q});
	assign last  = (cnt_q == CNT_W'(WORD_BITS - 1));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			fix_q  <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= fix_q;
			fix_q  <= busy_q && last;
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + CNT_W'(1);
				if (last) begin
					busy_q <= 1'b0;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			div_q <= req.is_div;
			neg_q <= a[WORD_BITS-1] ^ b[WORD_BITS-1];
			r_q   <= '0;
			if (req.is_div) begin
				x_q <= mag_a;
				y_q <= mag_b;
			end else begin
				x_q <= b;
				y_q <= a;
			end
		end else if (busy_q) begin
			if (div_q) begin
				r_q <= ge ? diff[WORD_BITS-1:0] : trial[WORD_BITS-1:0];
				x_q <= {x_q[WORD_BITS-2:0], ge};
			end else begin
				r_q <= r_q + (x_q[0] ? y_q : '0);
				x_q <= x_q >> 1;
				y_q <= y_q << 1;
			end
		end
		if (fix_q) begin
			if (div_q) begin
				res_q <= neg_q ? (~x_q + WORD_BITS'(1)) : x_q;
			end else begin
				res_q <= r_q;
			end
		end
	end

	assign done   = done_q;
	assign result = res_q;

endmodule

// ===== rtl/tiny_machine_executor.sv =====
// Top level of the tiny machine executor: sequencer, register file, data memory and multiply/divide unit.
//
//  channel | signals                                        | direction
//  --------+------------------------------------------------+----------
//  in      | in_valid, in_stall, func, dest_reg,            | into block
//          | second_operand, third_reg                      |
//  out     | out_valid, out_stall, status, value            | out of block
//
// After reset a clearing pass writes zero over all MEM_WORDS words (and the
// register file); in_stall stays high throughout.
// Each instruction passes S_IDLE, S_RD and S_FIN; LD and ST add S_ADDR, LD also
// S_MEM, and MUL and DIV wait in S_MD until the bit-serial unit is done.
// A finished result waits in the output register; the sequencer holds only
// when the next result finds that register still stalled.
module tiny_machine_executor #(
	parameter int MEM_WORDS = tme_pkg::MEM_WORDS_DEF,
	parameter int NUM_REGS  = tme_pkg::NUM_REGS_DEF,
	parameter int WORD_BITS = tme_pkg::WORD_BITS_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_stall,
	input  logic [3:0]         func,
	input  logic [2:0]         dest_reg,
	input  logic signed [31:0] second_operand,
	input  logic [2:0]         third_reg,
	output logic               out_valid,
	input  logic               out_stall,
	output logic [2:0]         status,
	output logic signed [31:0] value
);
	import tme_pkg::*;

	localparam int AW     = $clog2(MEM_WORDS);
	localparam int RIDX_W = $clog2(NUM_REGS);
	localparam int SUM_W  = ((WORD_BITS > 32) ? WORD_BITS : 32) + 1;

	typedef enum logic [6:0] {
		S_CLR  = 7'b0000001,
		S_IDLE = 7'b0000010,
		S_RD   = 7'b0000100,
		S_ADDR = 7'b0001000,
		S_MEM  = 7'b0010000,
		S_MD   = 7'b0100000,
		S_FIN  = 7'b1000000
	} state_t;

	state_t state_q;
	state_t state_d;

	logic [AW-1:0]  clr_q;
	logic           stopped_q;
	logic           out_valid_q;
	logic           wr_reg_q;
	logic           wr_reg_d;
	logic           wr_mem_q;
	logic           wr_mem_d;
	logic           stop_q;
	logic           stop_d;

	logic [3:0]               func_q;
	logic [2:0]               rd_q;
	logic signed [31:0]       sop_q;
	logic [2:0]               rt_q;
	logic signed [SUM_W-1:0]  sum_q;
	logic [2:0]               status_q;
	logic [2:0]               status_d;
	logic [WORD_BITS-1:0]     res_q;
	logic [WORD_BITS-1:0]     res_d;
	logic [2:0]               out_status_q;
	logic [31:0]              out_value_q;

	logic                 in_acc;
	logic                 fire;
	logic                 clr_last;
	logic                 clr_rf;
	logic                 is_arith_in;
	logic [31:0]          rd_in_ext;
	logic [31:0]          rt_in_ext;
	logic [31:0]          rd_ext;
	logic                 rd_ok;
	logic                 rt_ok;
	logic                 sop_ok;
	logic                 addr_ok;
	logic [63:0]          sop_wide;
	logic [63:0]          res_wide;
	logic [RIDX_W-1:0]    ra_addr;
	logic [RIDX_W-1:0]    rb_addr;
	logic                 rf_we;
	logic [RIDX_W-1:0]    rf_wa;
	logic [WORD_BITS-1:0] rf_wd;
	logic [WORD_BITS-1:0] a_data;
	logic [WORD_BITS-1:0] b_data;
	logic                 dm_rd;
	logic                 dm_en;
	logic                 dm_we;
	logic [AW-1:0]        dm_addr;
	logic [WORD_BITS-1:0] dm_wdata;
	logic [WORD_BITS-1:0] dm_rdata;
	md_req_t              md_req;
	logic                 md_done;
	logic [WORD_BITS-1:0] md_res;

	assign in_stall = (state_q != S_IDLE);
	assign in_acc   = in_valid && (state_q == S_IDLE);
	assign fire     = (state_q == S_FIN) && (!out_valid_q || !out_stall);
	assign clr_last = (clr_q == AW'(MEM_WORDS - 1));
	assign clr_rf   = (state_q == S_CLR) && ({1'b0, clr_q} < (AW + 1)'(NUM_REGS));

	assign is_arith_in = (func >= OP_ADD) && (func <= OP_DIV);
	assign rd_in_ext   = 32'(dest_reg);
	assign rt_in_ext   = 32'(third_reg);
	assign ra_addr     = is_arith_in ? second_operand[RIDX_W-1:0] : rd_in_ext[RIDX_W-1:0];
	assign rb_addr     = rt_in_ext[RIDX_W-1:0];

	assign rd_ext   = 32'(rd_q);
	assign rd_ok    = (rd_ext < 32'(NUM_REGS));
	assign rt_ok    = (32'(rt_q) < 32'(NUM_REGS));
	assign sop_ok   = ($unsigned(sop_q) < 32'(NUM_REGS));
	assign addr_ok  = !sum_q[SUM_W-1] && ($unsigned(sum_q) < SUM_W'(MEM_WORDS));
	assign sop_wide = 64'($unsigned(sop_q));
	assign res_wide = 64'(res_q);

	assign rf_we = clr_rf || (fire && wr_reg_q);
	assign rf_wa = clr_rf ? clr_q[RIDX_W-1:0] : rd_ext[RIDX_W-1:0];
	assign rf_wd = clr_rf ? '0 : res_q;

	assign dm_en    = (state_q == S_CLR) || dm_rd || (fire && wr_mem_q);
	assign dm_we    = (state_q == S_CLR) || (fire && wr_mem_q);
	assign dm_addr  = (state_q == S_CLR) ? clr_q : sum_q[AW-1:0];
	assign dm_wdata = (state_q == S_CLR) ? '0 : res_q;

	tme_regfile #(
		.NUM_REGS  (NUM_REGS),
		.WORD_BITS (WORD_BITS),
		.RIDX_W    (RIDX_W)
	) u_regfile (
		.clk     (clk),
		.re      (in_acc),
		.ra_addr (ra_addr),
		.rb_addr (rb_addr),
		.we      (rf_we),
		.wa_addr (rf_wa),
		.wdata   (rf_wd),
		.ra_data (a_data),
		.rb_data (b_data)
	);

	tme_dmem #(
		.MEM_WORDS (MEM_WORDS),
		.WORD_BITS (WORD_BITS),
		.AW        (AW)
	) u_dmem (
		.clk   (clk),
		.en    (dm_en),
		.we    (dm_we),
		.addr  (dm_addr),
		.wdata (dm_wdata),
		.rdata (dm_rdata)
	);

	tme_muldiv #(
		.WORD_BITS (WORD_BITS)
	) u_muldiv (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (md_req),
		.a      (a_data),
		.b      (b_data),
		.done   (md_done),
		.result (md_res)
	);

	always_comb begin
		state_d  = state_q;
		status_d = status_q;
		res_d    = res_q;
		wr_reg_d = wr_reg_q;
		wr_mem_d = wr_mem_q;
		stop_d   = stop_q;
		dm_rd    = 1'b0;
		md_req   = '0;
		unique case (state_q)
			S_CLR: begin
				if (clr_last) begin
					state_d = S_IDLE;
				end
			end
			S_IDLE: begin
				if (in_acc) begin
					state_d  = S_RD;
					status_d = ST_OK;
					res_d    = '0;
					wr_reg_d = 1'b0;
					wr_mem_d = 1'b0;
					stop_d   = 1'b0;
				end
			end
			S_RD: begin
				state_d = S_FIN;
				priority if (stopped_q) begin
					status_d = ST_STOPPED;
				end else if (func_q > OP_HALT) begin
					status_d = ST_UNKNOWN;
				end else if (func_q == OP_HALT) begin
					status_d = ST_HALT;
					stop_d   = 1'b1;
				end else if (!rd_ok) begin
					status_d = ST_BADREG;
				end else if (func_q == OP_LD || func_q == OP_ST) begin
					if (!rt_ok) begin
						status_d = ST_BADREG;
					end else begin
						state_d = S_ADDR;
					end
				end else if (func_q == OP_LDC) begin
					res_d    = sop_wide[WORD_BITS-1:0];
					wr_reg_d = 1'b1;
				end else if (func_q == OP_OUT) begin
					res_d    = a_data;
					status_d = ST_OUT;
				end else if (!sop_ok || !rt_ok) begin
					status_d = ST_BADREG;
				end else if (func_q == OP_ADD) begin
					res_d    = a_data + b_data;
					wr_reg_d = 1'b1;
				end else if (func_q == OP_SUB) begin
					res_d    = a_data - b_data;
					wr_reg_d = 1'b1;
				end else if (func_q == OP_DIV && b_data == '0) begin
					status_d = ST_DIVZ;
					stop_d   = 1'b1;
				end else begin
					md_req.start  = 1'b1;
					md_req.is_div = (func_q == OP_DIV);
					state_d       = S_MD;
				end
			end
			S_ADDR: begin
				state_d = S_FIN;
				priority if (!addr_ok) begin
					status_d = ST_BADADDR;
				end else if (func_q == OP_LD) begin
					dm_rd   = 1'b1;
					state_d = S_MEM;
				end else begin
					res_d    = a_data;
					wr_mem_d = 1'b1;
				end
			end
			S_MEM: begin
				res_d    = dm_rdata;
				wr_reg_d = 1'b1;
				state_d  = S_FIN;
			end
			S_MD: begin
				if (md_done) begin
					res_d    = md_res;
					wr_reg_d = 1'b1;
					state_d  = S_FIN;
				end
			end
			S_FIN: begin
				if (fire) begin
					state_d = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_CLR;
			clr_q       <= '0;
			stopped_q   <= 1'b0;
			out_valid_q <= 1'b0;
			wr_reg_q    <= 1'b0;
			wr_mem_q    <= 1'b0;
			stop_q      <= 1'b0;
		end else begin
			state_q  <= state_d;
			wr_reg_q <= wr_reg_d;
			wr_mem_q <= wr_mem_d;
			stop_q   <= stop_d;
			if (state_q == S_CLR) begin
				clr_q <= clr_q + AW'(1);
			end
			if (fire && stop_q) begin
				stopped_q <= 1'b1;
			end
			if (fire) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		status_q <= status_d;
		res_q    <= res_d;
		if (in_acc) begin
			func_q <= func;
			rd_q   <= dest_reg;
			sop_q  <= second_operand;
			rt_q   <= third_reg;
		end
		if (state_q == S_RD) begin
			sum_q <= SUM_W'(sop_q) + SUM_W'($signed(b_data));
		end
		if (fire) begin
			out_status_q <= status_q;
			out_value_q  <= res_wide[31:0];
		end
	end

	assign out_valid = out_valid_q;
	assign status    = out_status_q;
	assign value     = out_value_q;

endmodule
